[hdl/stm_pkg.sv]
// ============================================================================
// stm_pkg: shared types and constants of the six-actuator thrust mixer.
// Holds the Q1.14 constants, the quotient saturation limits and the beat
// formats passed between the mixing front end and the pipelined divider.
// ============================================================================
package stm_pkg;

    localparam logic [14:0] Q_ONE = 15'd16384;
    localparam logic signed [14:0] W_POINT3 = 15'sd4915;

    localparam logic [15:0] RES_MAX = 16'h7FFF;
    localparam logic [15:0] RES_MIN = 16'h8000;
    localparam logic [15:0] NEG_LIMIT = 16'd32768;

    localparam int DIV_STAGES = 4;
    localparam int DIV_STEPS = 4;

    typedef struct packed {
        logic [14:0] left_act_one;
        logic [14:0] left_act_two;
        logic [14:0] left_act_three;
        logic [14:0] right_act_one;
        logic [14:0] right_act_two;
        logic [14:0] right_act_three;
        logic [14:0] left_thrust;
        logic [14:0] right_thrust;
        logic        hit_lower;
        logic        hit_upper;
        logic        hit_attitude;
    } side_t;

    typedef struct packed {
        logic [16:0] mag;
        logic [14:0] gain;
        logic        neg;
        logic        ovf;
        logic        zero;
    } div_in_t;

    typedef struct packed {
        logic [15:0] quo;
        logic        neg;
        logic        ovf;
        logic        zero;
    } div_out_t;

endpackage

[hdl/six_actuator_thrust_mixer.sv]
// ============================================================================
// six_actuator_thrust_mixer: two-sided, six-actuator thrust mixer.
// Forms side thrust and six actuator values from roll, pitch, yaw and
// throttle demands, plus the compensated throttle and limit flags.
// ============================================================================
// A beat is taken at a rising edge where start is high and busy is low.
// Busy is always low: the block is a fully pipelined datapath and takes a
// new beat in every cycle, so throughput is one result per clock.
// Roll, pitch and yaw demands are signed Q1.14, the throttle demand is
// unsigned Q1.14, and all are sampled in the start cycle. The result beat
// appears on the output ports with done high for exactly one cycle.
// Results leave in the order the beats came in, one for each beat.
// Each beat passes four mixing stages, four divider stages that each
// resolve four quotient bits, and the output register.
// Asynchronous reset clears all valid bits, so no result is delivered for a
// beat that was in flight when reset was asserted.
// The receiver has no way to stall the block and must take each result in
// the cycle that done marks.
// ============================================================================
module six_actuator_thrust_mixer
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] roll_demand,
    input  logic signed [15:0] roll_feedfwd,
    input  logic signed [15:0] pitch_demand,
    input  logic signed [15:0] pitch_feedfwd,
    input  logic signed [15:0] yaw_demand,
    input  logic signed [15:0] yaw_feedfwd,
    input  logic [14:0]        throttle_demand,
    input  logic [14:0]        comp_gain,
    input  logic [14:0]        throttle_ceiling,
    output logic               done,
    output logic [14:0]        left_act_one,
    output logic [14:0]        left_act_two,
    output logic [14:0]        left_act_three,
    output logic [14:0]        right_act_one,
    output logic [14:0]        right_act_two,
    output logic [14:0]        right_act_three,
    output logic [14:0]        left_thrust,
    output logic [14:0]        right_thrust,
    output logic signed [15:0] throttle_result,
    output logic               hit_lower,
    output logic               hit_upper,
    output logic               hit_attitude
);

    logic              mix_valid;
    stm_pkg::div_in_t  mix_div;
    stm_pkg::side_t    mix_side;
    logic              div_valid;
    stm_pkg::div_out_t div_res;
    stm_pkg::side_t    div_side;

    logic              done_reg;
    stm_pkg::side_t    side_reg;
    logic [15:0]       result_reg, result_next;

    assign busy = 1'b0;

    stm_mix u_mix
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (start && !busy),
        .roll_demand      (roll_demand),
        .roll_feedfwd     (roll_feedfwd),
        .pitch_demand     (pitch_demand),
        .pitch_feedfwd    (pitch_feedfwd),
        .yaw_demand       (yaw_demand),
        .yaw_feedfwd      (yaw_feedfwd),
        .throttle_demand  (throttle_demand),
        .comp_gain        (comp_gain),
        .throttle_ceiling (throttle_ceiling),
        .out_valid        (mix_valid),
        .div_in           (mix_div),
        .side             (mix_side)
    );

    stm_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mix_valid),
        .div_in    (mix_div),
        .side_in   (mix_side),
        .out_valid (div_valid),
        .div_out   (div_res),
        .side_out  (div_side)
    );

    always_comb
    begin
        if (div_res.zero)
            result_next = '0;
        else if (div_res.ovf)
            result_next = div_res.neg ? stm_pkg::RES_MIN : stm_pkg::RES_MAX;
        else if (div_res.neg)
            result_next = (div_res.quo > stm_pkg::NEG_LIMIT) ? stm_pkg::RES_MIN
                                                             : 16'(~div_res.quo + 16'd1);
        else
            result_next = (div_res.quo > stm_pkg::RES_MAX) ? stm_pkg::RES_MAX
                                                           : div_res.quo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        side_reg   <= div_side;
        result_reg <= result_next;
    end

    assign done            = done_reg;
    assign left_act_one    = side_reg.left_act_one;
    assign left_act_two    = side_reg.left_act_two;
    assign left_act_three  = side_reg.left_act_three;
    assign right_act_one   = side_reg.right_act_one;
    assign right_act_two   = side_reg.right_act_two;
    assign right_act_three = side_reg.right_act_three;
    assign left_thrust     = side_reg.left_thrust;
    assign right_thrust    = side_reg.right_thrust;
    assign throttle_result = $signed(result_reg);
    assign hit_lower       = side_reg.hit_lower;
    assign hit_upper       = side_reg.hit_upper;
    assign hit_attitude    = side_reg.hit_attitude;

    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##9 done)
        else $error("accepted beat did not produce a result after nine cycles");

    a_att_upper : assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit_attitude) |-> hit_upper)
        else $error("attitude limit flagged without upper limit");

    a_att_full : assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit_attitude) |->
        (left_thrust == stm_pkg::Q_ONE || right_thrust == stm_pkg::Q_ONE))
        else $error("attitude limit without a side at full thrust");

endmodule

[hdl/stm_mix.sv]
// ============================================================================
// stm_mix: mixing front end.
// Four register stages: gain scaling, throttle clamp and tilt weighting,
// side thrust adjustment, then actuator clamps and divider operand setup.
// ============================================================================
module stm_mix
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic signed [15:0]    roll_demand,
    input  logic signed [15:0]    roll_feedfwd,
    input  logic signed [15:0]    pitch_demand,
    input  logic signed [15:0]    pitch_feedfwd,
    input  logic signed [15:0]    yaw_demand,
    input  logic signed [15:0]    yaw_feedfwd,
    input  logic [14:0]           throttle_demand,
    input  logic [14:0]           comp_gain,
    input  logic [14:0]           throttle_ceiling,
    output logic                  out_valid,
    output stm_pkg::div_in_t      div_in,
    output stm_pkg::side_t        side
);

    localparam logic signed [17:0] ONE_S18 = 18'(stm_pkg::Q_ONE);

    typedef struct packed {
        logic signed [17:0] r;
        logic signed [17:0] p;
        logic signed [17:0] y;
        logic [15:0]        t;
        logic [14:0]        ceil_v;
        logic [14:0]        gain;
    } s1_t;

    typedef struct packed {
        logic signed [17:0] lt;
        logic signed [17:0] rt;
        logic [14:0]        tc;
        logic signed [31:0] wy;
        logic signed [31:0] wtl;
        logic signed [31:0] wtr;
        logic [14:0]        gain;
        logic               lower;
        logic               upper;
    } s2_t;

    typedef struct packed {
        logic [14:0]        lthr;
        logic [14:0]        rthr;
        logic signed [17:0] wy;
        logic signed [17:0] wtl;
        logic signed [17:0] wtr;
        logic signed [17:0] thr;
        logic [14:0]        gain;
        logic               lower;
        logic               upper;
        logic               att;
    } s3_t;

    function automatic logic [14:0] clamp_unit(input logic signed [18:0] v);
        logic [14:0] res;
        if (v < 19'sd0)
            res = '0;
        else if (v > 19'(stm_pkg::Q_ONE))
            res = stm_pkg::Q_ONE;
        else
            res = v[14:0];
        return res;
    endfunction

    s1_t     s1_reg, s1_next;
    s2_t     s2_reg, s2_next;
    s3_t     s3_reg, s3_next;
    stm_pkg::div_in_t s4_div_reg, s4_div_next;
    stm_pkg::side_t   s4_side_reg, s4_side_next;
    logic    s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;

    logic signed [16:0] roll_sum, pitch_sum, yaw_sum;
    logic signed [32:0] roll_prod, pitch_prod, yaw_prod;
    logic [29:0]        thr_prod;

    logic [15:0]        t0;
    logic signed [16:0] half;
    logic signed [18:0] tl, tr;

    logic signed [17:0] m, adj;

    always_comb
    begin
        roll_sum   = 17'(roll_demand) + 17'(roll_feedfwd);
        pitch_sum  = 17'(pitch_demand) + 17'(pitch_feedfwd);
        yaw_sum    = 17'(yaw_demand) + 17'(yaw_feedfwd);
        roll_prod  = 33'(roll_sum) * $signed({18'd0, comp_gain});
        pitch_prod = 33'(pitch_sum) * $signed({18'd0, comp_gain});
        yaw_prod   = 33'(yaw_sum) * $signed({18'd0, comp_gain});
        thr_prod   = 30'(throttle_demand) * 30'(comp_gain);
        s1_next.r      = roll_prod[31:14];
        s1_next.p      = pitch_prod[31:14];
        s1_next.y      = yaw_prod[31:14];
        s1_next.t      = thr_prod[29:14];
        s1_next.ceil_v = throttle_ceiling;
        s1_next.gain   = comp_gain;
    end

    always_comb
    begin
        s2_next.lower = (s1_reg.t == 16'd0);
        t0 = s2_next.lower ? 16'd0 : s1_reg.t;
        s2_next.upper = (t0 >= {1'b0, s1_reg.ceil_v});
        s2_next.tc = s2_next.upper ? s1_reg.ceil_v : t0[14:0];
        half = s1_reg.r[17:1];
        s2_next.lt = $signed({3'b000, s2_next.tc}) + 18'(half);
        s2_next.rt = $signed({3'b000, s2_next.tc}) - 18'(half);
        tl = 19'(s1_reg.p) - 19'(s1_reg.y);
        tr = 19'(s1_reg.p) + 19'(s1_reg.y);
        s2_next.wy  = 32'(s1_reg.y) * 32'(stm_pkg::W_POINT3);
        s2_next.wtl = 32'(tl) * 32'(stm_pkg::W_POINT3);
        s2_next.wtr = 32'(tr) * 32'(stm_pkg::W_POINT3);
        s2_next.gain = s1_reg.gain;
    end

    always_comb
    begin
        m = (s2_reg.lt > s2_reg.rt) ? s2_reg.lt : s2_reg.rt;
        s3_next.att = (m > ONE_S18);
        adj = s3_next.att ? (ONE_S18 - m) : 18'sd0;
        s3_next.lthr  = clamp_unit(19'(s2_reg.lt) + 19'(adj));
        s3_next.rthr  = clamp_unit(19'(s2_reg.rt) + 19'(adj));
        s3_next.thr   = $signed({3'b000, s2_reg.tc}) + adj;
        s3_next.wy    = s2_reg.wy[31:14];
        s3_next.wtl   = s2_reg.wtl[31:14];
        s3_next.wtr   = s2_reg.wtr[31:14];
        s3_next.gain  = s2_reg.gain;
        s3_next.lower = s2_reg.lower;
        s3_next.upper = s2_reg.upper | s3_next.att;
    end

    always_comb
    begin
        s4_side_next.left_act_one    = clamp_unit($signed({4'b0, s3_reg.lthr}) - 19'(s3_reg.wy));
        s4_side_next.left_act_two    = clamp_unit($signed({4'b0, s3_reg.lthr}) - 19'(s3_reg.wtl));
        s4_side_next.left_act_three  = clamp_unit($signed({4'b0, s3_reg.lthr}) + 19'(s3_reg.wtl));
        s4_side_next.right_act_one   = clamp_unit($signed({4'b0, s3_reg.rthr}) + 19'(s3_reg.wy));
        s4_side_next.right_act_two   = clamp_unit($signed({4'b0, s3_reg.rthr}) - 19'(s3_reg.wtr));
        s4_side_next.right_act_three = clamp_unit($signed({4'b0, s3_reg.rthr}) + 19'(s3_reg.wtr));
        s4_side_next.left_thrust     = s3_reg.lthr;
        s4_side_next.right_thrust    = s3_reg.rthr;
        s4_side_next.hit_lower       = s3_reg.lower;
        s4_side_next.hit_upper       = s3_reg.upper;
        s4_side_next.hit_attitude    = s3_reg.att;
        s4_div_next.neg  = (s3_reg.thr < 18'sd0);
        s4_div_next.mag  = s4_div_next.neg ? 17'(-s3_reg.thr) : 17'(s3_reg.thr);
        s4_div_next.gain = s3_reg.gain;
        s4_div_next.zero = (s4_div_next.mag == 17'd0);
        s4_div_next.ovf  = !s4_div_next.zero && (s4_div_next.mag >= {s3_reg.gain, 2'b00});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg      <= s1_next;
        s2_reg      <= s2_next;
        s3_reg      <= s3_next;
        s4_div_reg  <= s4_div_next;
        s4_side_reg <= s4_side_next;
    end

    assign out_valid = s4_valid_reg;
    assign div_in    = s4_div_reg;
    assign side      = s4_side_reg;

endmodule

[hdl/stm_div.sv]
// ============================================================================
// stm_div: pipelined restoring divider.
// Divides the throttle magnitude, scaled by 1.0, by the gain, four quotient
// bits per stage, and carries the mixer results alongside each beat.
// ============================================================================
module stm_div
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  stm_pkg::div_in_t      div_in,
    input  stm_pkg::side_t        side_in,
    output logic                  out_valid,
    output stm_pkg::div_out_t     div_out,
    output stm_pkg::side_t        side_out
);

    typedef struct packed {
        logic [14:0] rem;
        logic [15:0] quo;
        logic [15:0] low;
        logic [14:0] gain;
        logic        neg;
        logic        ovf;
        logic        zero;
    } div_work_t;

    div_work_t      entry;
    div_work_t      work_reg  [stm_pkg::DIV_STAGES];
    div_work_t      work_next [stm_pkg::DIV_STAGES];
    stm_pkg::side_t side_reg  [stm_pkg::DIV_STAGES];
    logic [stm_pkg::DIV_STAGES-1:0] valid_reg;

    always_comb
    begin
        entry.rem  = div_in.mag[16:2];
        entry.low  = {div_in.mag[1:0], 14'd0};
        entry.quo  = '0;
        entry.gain = div_in.gain;
        entry.neg  = div_in.neg;
        entry.ovf  = div_in.ovf;
        entry.zero = div_in.zero;
    end

    for (genvar g = 0; g < stm_pkg::DIV_STAGES; g++)
    begin : g_stage
        div_work_t src;
        logic [15:0] rem2;

        if (g == 0)
        begin : g_first
            assign src = entry;
        end
        else
        begin : g_rest
            assign src = work_reg[g-1];
        end

        always_comb
        begin
            work_next[g] = src;
            rem2 = '0;
            for (int k = 0; k < stm_pkg::DIV_STEPS; k++)
            begin
                rem2 = {work_next[g].rem, work_next[g].low[15]};
                work_next[g].low = {work_next[g].low[14:0], 1'b0};
                if (rem2 >= {1'b0, work_next[g].gain})
                begin
                    work_next[g].rem = 15'(rem2 - {1'b0, work_next[g].gain});
                    work_next[g].quo = {work_next[g].quo[14:0], 1'b1};
                end
                else
                begin
                    work_next[g].rem = rem2[14:0];
                    work_next[g].quo = {work_next[g].quo[14:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            work_reg[g] <= work_next[g];
            if (g == 0)
                side_reg[g] <= side_in;
            else
                side_reg[g] <= side_reg[(g == 0) ? 0 : g-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[stm_pkg::DIV_STAGES-2:0], in_valid};
    end

    assign out_valid     = valid_reg[stm_pkg::DIV_STAGES-1];
    assign div_out.quo   = work_reg[stm_pkg::DIV_STAGES-1].quo;
    assign div_out.neg   = work_reg[stm_pkg::DIV_STAGES-1].neg;
    assign div_out.ovf   = work_reg[stm_pkg::DIV_STAGES-1].ovf;
    assign div_out.zero  = work_reg[stm_pkg::DIV_STAGES-1].zero;
    assign side_out      = side_reg[stm_pkg::DIV_STAGES-1];

endmodule
